[rtl/core/dwpi_pkg.sv]
// ----------------------------------------------------------------------------
// dwpi_pkg : shared types and constants of the dual wheel PI drive
// Word layouts, register indexes, lane and merge interfaces, saturation.
// ----------------------------------------------------------------------------
package dwpi_pkg;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] REG_LEFT_PROP   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LEFT_INTEG  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RIGHT_PROP  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RIGHT_INTEG = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COUNT_SCALE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_START_LIMIT = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RUN_LIMIT   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_START_DIST  = 3'd7;

  localparam logic [15:0] CountScaleReset = 16'd256;

  // Default bridge wiring: left forward on channel A
  localparam int DefWiringVariant = 0;

  // Division by ten, one byte of the dividend per step
  localparam int          DivW        = 48;
  localparam int          DivDigitW   = 8;
  localparam int          DivSteps    = DivW / DivDigitW;
  localparam logic [12:0] Div10Recip  = 13'd6554;   // ceil(2^16 / 10)
  localparam int          Div10Shift  = 16;

  typedef struct packed {
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic signed [23:0] left_target;
    logic signed [23:0] right_target;
  } in_word_t;

  typedef struct packed {
    logic [14:0] left_duty_a;
    logic [14:0] left_duty_b;
    logic [14:0] right_duty_a;
    logic [14:0] right_duty_b;
    logic        in_start_phase;
  } out_word_t;

  typedef struct packed {
    logic [9:0]  left_prop_gain;
    logic [9:0]  left_integ_gain;
    logic [9:0]  right_prop_gain;
    logic [9:0]  right_integ_gain;
    logic [15:0] count_scale;
    logic [14:0] start_drive_limit;
    logic [14:0] run_drive_limit;
    logic [30:0] start_distance;
  } cfg_t;

  // Work handed to one wheel lane (count already carries the wheel's sign)
  typedef struct packed {
    logic               start;
    logic signed [16:0] count;
    logic signed [23:0] target;
    logic [9:0]         prop_gain;
    logic [9:0]         integ_gain;
  } lane_cmd_t;

  // What one lane found for the current word
  typedef struct packed {
    logic               done;
    logic signed [40:0] inc;
    logic signed [23:0] speed_trunc;
  } lane_res_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } merge_out_t;

  // Saturate a 33-bit signed value to the signed 32-bit range
  function automatic logic [31:0] sat_s32(input logic [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/core/dwpi_div10.sv]
// ----------------------------------------------------------------------------
// dwpi_div10 : unsigned division by ten
// Long division one byte per cycle; each digit by a reciprocal multiply.
// ----------------------------------------------------------------------------
module dwpi_div10 (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [dwpi_pkg::DivW-1:0] dividend,
  output logic [dwpi_pkg::DivW-1:0] quotient,
  output logic                     done
);
  import dwpi_pkg::*;

  localparam int StepW = $clog2(DivSteps);

  logic                 busy_r;
  logic                 done_r;
  logic [StepW-1:0]     step_r;
  logic [3:0]           rem_r;
  logic [DivW-1:0]      work_r;
  logic [DivW-1:0]      quot_r;

  logic [11:0]          part;
  logic [24:0]          recip_prod;
  logic [7:0]           digit;
  logic [11:0]          digit_x10;
  logic [11:0]          rem_full;

  // Bring down the next byte and split it into digit and remainder
  assign part       = {rem_r, work_r[DivW-1 -: DivDigitW]};
  assign recip_prod = {13'd0, part} * {12'd0, Div10Recip};
  assign digit      = recip_prod[Div10Shift +: 8];
  assign digit_x10  = {1'b0, digit, 3'd0} + {3'd0, digit, 1'b0};
  assign rem_full   = part - digit_x10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= StepW'(DivSteps - 1);
        rem_r  <= 4'd0;
        work_r <= dividend;
      end else if (busy_r) begin
        rem_r  <= rem_full[3:0];
        work_r <= {work_r[DivW-DivDigitW-1:0], {DivDigitW{1'b0}}};
        quot_r <= {quot_r[DivW-DivDigitW-1:0], digit};
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quot_r;
  assign done     = done_r;

endmodule

[rtl/core/dwpi_lane.sv]
// ----------------------------------------------------------------------------
// dwpi_lane : one wheel's speed, error and incremental PI step
// Measures speed, forms the error, and computes (kp*de + ki*e)/10.
// ----------------------------------------------------------------------------
module dwpi_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  dwpi_pkg::lane_cmd_t cmd,
  input  logic [15:0]         count_scale,
  output dwpi_pkg::lane_res_t res
);
  import dwpi_pkg::*;

  localparam logic [3:0] L_IDLE  = 4'd0;
  localparam logic [3:0] L_SPEED = 4'd1;
  localparam logic [3:0] L_ERR   = 4'd2;
  localparam logic [3:0] L_DIFF  = 4'd3;
  localparam logic [3:0] L_MULP  = 4'd4;
  localparam logic [3:0] L_MULI  = 4'd5;
  localparam logic [3:0] L_SUM   = 4'd6;
  localparam logic [3:0] L_ABS   = 4'd7;
  localparam logic [3:0] L_DIV   = 4'd8;

  logic [3:0]          state_r;
  logic signed [16:0]  count_r;
  logic signed [23:0]  target_r;
  logic [9:0]          kp_r;
  logic [9:0]          ki_r;
  logic signed [31:0]  speed_r;
  logic signed [23:0]  strunc_r;
  logic signed [31:0]  err_r;
  logic signed [31:0]  last_r;
  logic signed [32:0]  diff_r;
  logic signed [43:0]  prod_p_r;
  logic signed [42:0]  prod_i_r;
  logic signed [43:0]  sum_r;
  logic                neg_r;
  logic signed [40:0]  inc_r;
  logic                done_r;

  logic signed [33:0]  speed_full;
  logic [32:0]         err_full;
  logic [31:0]         strunc_full;
  logic [32:0]         diff_full;
  logic signed [43:0]  prod_p;
  logic signed [42:0]  prod_i;
  logic [43:0]         sum_abs;
  logic                div_start;
  logic [DivW-1:0]     div_dividend;
  logic [DivW-1:0]     div_quot;
  logic                div_done;
  logic [40:0]         quot_ext;

  // Datapath: one multiply or one wide add per cycle
  assign speed_full   = count_r * $signed({1'b0, count_scale});
  assign err_full     = {{9{target_r[23]}}, target_r} - {speed_r[31], speed_r};
  assign strunc_full  = speed_r + (speed_r[31] ? 32'd255 : 32'd0);
  assign diff_full    = {err_r[31], err_r} - {last_r[31], last_r};
  assign prod_p       = diff_r * $signed({1'b0, kp_r});
  assign prod_i       = err_r * $signed({1'b0, ki_r});
  assign sum_abs      = sum_r[43] ? 44'(-sum_r) : sum_r;
  assign div_start    = (state_r == L_ABS);
  assign div_dividend = {{(DivW-44){1'b0}}, sum_abs};
  assign quot_ext     = {1'b0, div_quot[39:0]};

  dwpi_div10 u_div10 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .quotient (div_quot),
    .done     (div_done)
  );

  // Sequence one word through the lane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
      last_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        L_IDLE: begin
          if (cmd.start) begin
            count_r  <= cmd.count;
            target_r <= cmd.target;
            kp_r     <= cmd.prop_gain;
            ki_r     <= cmd.integ_gain;
            state_r  <= L_SPEED;
          end
        end
        L_SPEED: begin
          speed_r <= speed_full[31:0];
          state_r <= L_ERR;
        end
        L_ERR: begin
          err_r    <= sat_s32(err_full);
          strunc_r <= strunc_full[31:8];
          state_r  <= L_DIFF;
        end
        L_DIFF: begin
          diff_r  <= diff_full;
          last_r  <= err_r;
          state_r <= L_MULP;
        end
        L_MULP: begin
          prod_p_r <= prod_p;
          state_r  <= L_MULI;
        end
        L_MULI: begin
          prod_i_r <= prod_i;
          state_r  <= L_SUM;
        end
        L_SUM: begin
          sum_r   <= prod_p_r + {prod_i_r[42], prod_i_r};
          state_r <= L_ABS;
        end
        L_ABS: begin
          neg_r   <= sum_r[43];
          state_r <= L_DIV;
        end
        L_DIV: begin
          if (div_done) begin
            inc_r   <= neg_r ? 41'(-quot_ext) : quot_ext;
            done_r  <= 1'b1;
            state_r <= L_IDLE;
          end
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign res.done        = done_r;
  assign res.inc         = inc_r;
  assign res.speed_trunc = strunc_r;

endmodule

[rtl/core/dwpi_merge.sv]
// ----------------------------------------------------------------------------
// dwpi_merge : drive update, clamping, distance count and bridge split
// Combines both lanes' increments, runs the start phase, forms duties.
// ----------------------------------------------------------------------------
module dwpi_merge #(
  parameter int WIRING_VARIANT = dwpi_pkg::DefWiringVariant
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dwpi_pkg::lane_res_t  left_res,
  input  dwpi_pkg::lane_res_t  right_res,
  input  dwpi_pkg::cfg_t       cfg,
  input  logic                 slot_free,
  output dwpi_pkg::merge_out_t result
);
  import dwpi_pkg::*;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_CLAMP_L = 3'd1;
  localparam logic [2:0] M_PHASE_L = 3'd2;
  localparam logic [2:0] M_CLAMP_R = 3'd3;
  localparam logic [2:0] M_PHASE_R = 3'd4;
  localparam logic [2:0] M_EMIT    = 3'd5;

  logic [2:0]          state_r;
  logic signed [23:0]  drive_l_r;
  logic signed [23:0]  drive_r_r;
  logic signed [41:0]  nd_l_r;
  logic signed [41:0]  nd_r_r;
  logic signed [24:0]  tsum_r;
  logic [31:0]         dist_r;
  logic                phase_r;

  logic [41:0]         lim;
  logic [32:0]         dist_full;
  logic                dist_over;
  logic [14:0]         mag_l;
  logic [14:0]         mag_r;
  out_word_t           word;

  // Clamp a widened drive to +-limit
  function automatic logic [23:0] clamp_drive(input logic [41:0] d, input logic [41:0] l);
    logic [41:0] nl;
    nl = -l;
    if ($signed(d) > $signed(l)) begin
      return l[23:0];
    end
    if ($signed(d) < $signed(nl)) begin
      return nl[23:0];
    end
    return d[23:0];
  endfunction

  // Integer duty magnitude of a Q.8 drive
  function automatic logic [14:0] duty_mag(input logic [23:0] d);
    logic [23:0] a;
    a = d[23] ? -d : d;
    return a[22:8];
  endfunction

  assign lim       = {19'd0, phase_r ? cfg.start_drive_limit : cfg.run_drive_limit, 8'd0};
  assign dist_full = {dist_r[31], dist_r} + {{8{tsum_r[24]}}, tsum_r};
  assign dist_over = $signed(dist_r) > $signed({1'b0, cfg.start_distance});
  assign mag_l     = duty_mag(drive_l_r);
  assign mag_r     = duty_mag(drive_r_r);

  // Split each drive onto its bridge
  always_comb begin
    word.left_duty_a    = drive_l_r[23] ? 15'd0 : mag_l;
    word.left_duty_b    = drive_l_r[23] ? mag_l : 15'd0;
    if (WIRING_VARIANT != 0) begin
      word.left_duty_a  = drive_l_r[23] ? mag_l : 15'd0;
      word.left_duty_b  = drive_l_r[23] ? 15'd0 : mag_l;
    end
    word.right_duty_a   = drive_r_r[23] ? mag_r : 15'd0;
    word.right_duty_b   = drive_r_r[23] ? 15'd0 : mag_r;
    word.in_start_phase = phase_r;
  end

  // Left clamp and count, then right clamp and count, then emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= M_IDLE;
      drive_l_r <= '0;
      drive_r_r <= '0;
      dist_r    <= '0;
      phase_r   <= 1'b1;
    end else begin
      unique case (state_r)
        M_IDLE: begin
          if (left_res.done && right_res.done) begin
            nd_l_r  <= {{18{drive_l_r[23]}}, drive_l_r} + {left_res.inc[40], left_res.inc};
            nd_r_r  <= {{18{drive_r_r[23]}}, drive_r_r} + {right_res.inc[40], right_res.inc};
            tsum_r  <= {left_res.speed_trunc[23], left_res.speed_trunc}
                     + {right_res.speed_trunc[23], right_res.speed_trunc};
            state_r <= M_CLAMP_L;
          end
        end
        M_CLAMP_L: begin
          drive_l_r <= clamp_drive(nd_l_r, lim);
          if (phase_r) begin
            dist_r <= sat_s32(dist_full);
          end
          state_r <= M_PHASE_L;
        end
        M_PHASE_L: begin
          if (phase_r && dist_over) begin
            phase_r <= 1'b0;
          end
          state_r <= M_CLAMP_R;
        end
        M_CLAMP_R: begin
          drive_r_r <= clamp_drive(nd_r_r, lim);
          if (phase_r) begin
            dist_r <= sat_s32(dist_full);
          end
          state_r <= M_PHASE_R;
        end
        M_PHASE_R: begin
          if (phase_r && dist_over) begin
            phase_r <= 1'b0;
          end
          state_r <= M_EMIT;
        end
        M_EMIT: begin
          if (slot_free) begin
            state_r <= M_IDLE;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign result.valid = (state_r == M_EMIT) && slot_free;
  assign result.word  = word;

endmodule

[rtl/core/dual_wheel_incremental_pi_drive.sv]
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pi_drive : two-wheel incremental PI motor drive
// One control tick per input word: encoder counts and targets in, duties out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one word per control tick with both encoder counts and both
//            target speeds (Q15.8). Taken when in_valid and in_ready are high.
//   out_*  : one result word per input word with the four bridge duties and
//            the start phase flag, held in an output register until taken.
//   cfg_*  : register writes by index, always ready; write only while idle.
// Flow: after a word is accepted, two wheel
//   lanes run side by side (speed multiply, error, two gain multiplies in
//   turn, six-step byte-wise division by ten), then the merge
//   sequencer clamps left, counts distance, clamps right, counts again.
//   The next word is accepted once the previous result is in the output
//   register, so no new word is taken before the previous one is through.
// Reset clears drives, errors and distance, enters the start phase and sets
//   count_scale to 1.0. A stalled receiver holds the result; a finished word
//   then waits in the merge stage and no new word is taken.
// ----------------------------------------------------------------------------
module dual_wheel_incremental_pi_drive #(
  parameter int WIRING_VARIANT = dwpi_pkg::DefWiringVariant
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dwpi_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dwpi_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dwpi_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [dwpi_pkg::CfgDataW-1:0]   cfg_data
);
  import dwpi_pkg::*;

  cfg_t        cfg_r;
  logic        busy_r;
  logic        out_valid_r;
  out_word_t   out_word_r;

  logic        in_take;
  logic        slot_free;
  lane_cmd_t   left_cmd;
  lane_cmd_t   right_cmd;
  lane_res_t   left_res;
  lane_res_t   right_res;
  merge_out_t  merged;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r;
  assign in_take   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{10'd0, 10'd0, 10'd0, 10'd0, CountScaleReset, 15'd0, 15'd0, 31'd0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEFT_PROP:   cfg_r.left_prop_gain    <= cfg_data[9:0];
        REG_LEFT_INTEG:  cfg_r.left_integ_gain   <= cfg_data[9:0];
        REG_RIGHT_PROP:  cfg_r.right_prop_gain   <= cfg_data[9:0];
        REG_RIGHT_INTEG: cfg_r.right_integ_gain  <= cfg_data[9:0];
        REG_COUNT_SCALE: cfg_r.count_scale       <= cfg_data[15:0];
        REG_START_LIMIT: cfg_r.start_drive_limit <= cfg_data[14:0];
        REG_RUN_LIMIT:   cfg_r.run_drive_limit   <= cfg_data[14:0];
        REG_START_DIST:  cfg_r.start_distance    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Hand each wheel its share of the word; the right count is negated
  always_comb begin
    left_cmd.start       = in_take;
    left_cmd.count       = {in_data.left_count[15], in_data.left_count};
    left_cmd.target      = in_data.left_target;
    left_cmd.prop_gain   = cfg_r.left_prop_gain;
    left_cmd.integ_gain  = cfg_r.left_integ_gain;
    right_cmd.start      = in_take;
    right_cmd.count      = 17'(-{in_data.right_count[15], in_data.right_count});
    right_cmd.target     = in_data.right_target;
    right_cmd.prop_gain  = cfg_r.right_prop_gain;
    right_cmd.integ_gain = cfg_r.right_integ_gain;
  end

  dwpi_lane u_lane_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (left_cmd),
    .count_scale (cfg_r.count_scale),
    .res         (left_res)
  );

  dwpi_lane u_lane_right (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (right_cmd),
    .count_scale (cfg_r.count_scale),
    .res         (right_res)
  );

  dwpi_merge #(
    .WIRING_VARIANT (WIRING_VARIANT)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .left_res  (left_res),
    .right_res (right_res),
    .cfg       (cfg_r),
    .slot_free (slot_free),
    .result    (merged)
  );

  // Hold one word in flight; release when its result lands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_take) begin
      busy_r <= 1'b1;
    end else if (merged.valid) begin
      busy_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (merged.valid) begin
      out_valid_r <= 1'b1;
      out_word_r  <= merged.word;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule
